/* hdl/mbsp_pkg.sv */
// Shared types, constants and the status length decode for the MIDI byte stream parser.
`default_nettype none
package mbsp_pkg;

  localparam int SYSEX_BUFFER_BYTES = 256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_RT    = 2'd1;
  localparam logic [1:0] KIND_SYSEX = 2'd2;

  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_EOX   = 8'hF7;
  localparam logic [7:0] RT_FIRST = 8'hF8;

  localparam logic [1:0] SYS_LEN [16] = '{
    2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] msg_length;
    logic [7:0] first_byte;
    logic [6:0] second_byte;
    logic [6:0] third_byte;
    logic       sysex_end;
  } result_t;

  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t r0;
    result_t r1;
  } result_pair_t;

  function automatic logic [1:0] status_length(input logic [7:0] b);
    logic [1:0] len;
    if (!b[7]) begin
      len = 2'd0;
    end else if (b[7:6] == 2'b10) begin
      len = 2'd3;
    end else if (b[7:5] == 3'b110) begin
      len = 2'd2;
    end else if (b[7:4] == 4'hE) begin
      len = 2'd3;
    end else begin
      len = SYS_LEN[b[3:0]];
    end
    return len;
  endfunction

endpackage
`default_nettype wire

/* hdl/midi_byte_stream_parser.sv */
// Top level of the MIDI byte stream parser with running status.
// A result is written into the result queue when its input beat is taken and is
// offered from the queue head. Throughput: one byte per cycle while input is not
// stalled; a status byte that closes a sysex can give two results, and input is
// stalled while three or more results wait. Synchronous reset clears running
// status, length, position, sysex fill and the result queue.
`default_nettype none
module midi_byte_stream_parser #(
  parameter int SYSEX_BUFFER_BYTES = mbsp_pkg::SYSEX_BUFFER_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [1:0]      msg_length,
  output logic [7:0]      first_byte,
  output logic [6:0]      second_byte,
  output logic [6:0]      third_byte,
  output logic            sysex_end
);

  mbsp_pkg::result_pair_t res;
  mbsp_pkg::result_t      head;
  logic                   full;
  logic                   beat_acc;

  assign in_stall = full;
  assign beat_acc = in_valid && !full;

  mbsp_parse #(
    .SYSEX_BUFFER_BYTES(SYSEX_BUFFER_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .beat_acc (beat_acc),
    .in_byte  (in_byte),
    .res      (res)
  );

  mbsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .beat_acc   (beat_acc),
    .res        (res),
    .full       (full),
    .head_vld   (out_valid),
    .head_stall (out_stall),
    .head       (head)
  );

  assign kind        = head.kind;
  assign msg_length  = head.msg_length;
  assign first_byte  = head.first_byte;
  assign second_byte = head.second_byte;
  assign third_byte  = head.third_byte;
  assign sysex_end   = head.sysex_end;

endmodule
`default_nettype wire

/* hdl/mbsp_parse.sv */
// Per-byte framing logic and running status state.
`default_nettype none
module mbsp_parse #(
  parameter int SYSEX_BUFFER_BYTES = mbsp_pkg::SYSEX_BUFFER_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 beat_acc,
  input  wire logic [7:0]           in_byte,
  output mbsp_pkg::result_pair_t    res
);

  localparam int FW = $clog2(SYSEX_BUFFER_BYTES);
  localparam logic [FW-1:0] FILL_MAX = FW'(SYSEX_BUFFER_BYTES - 1);

  logic [7:0]    running_status, running_status_next;
  logic [1:0]    expected_length, expected_length_next;
  logic [1:0]    byte_position, byte_position_next;
  logic [7:0]    mb0, mb0_next;
  logic [6:0]    mb1, mb1_next;
  logic [6:0]    mb2, mb2_next;
  logic [FW-1:0] sysex_fill, sysex_fill_next;

  mbsp_pkg::result_t main_res;
  mbsp_pkg::result_t close_res;
  logic              main_vld;
  logic              close_vld;
  logic [1:0]        pos;
  logic [2:0]        pos1;

  always_comb begin
    running_status_next  = running_status;
    expected_length_next = expected_length;
    byte_position_next   = byte_position;
    mb0_next             = mb0;
    mb1_next             = mb1;
    mb2_next             = mb2;
    sysex_fill_next      = sysex_fill;
    main_vld             = 1'b0;
    close_vld            = 1'b0;
    main_res             = '0;
    close_res            = '{kind: mbsp_pkg::KIND_SYSEX, msg_length: 2'd1,
                             first_byte: mbsp_pkg::ST_EOX, second_byte: 7'd0,
                             third_byte: 7'd0, sysex_end: 1'b1};
    pos                  = byte_position;
    pos1                 = 3'd0;
    if (in_byte >= mbsp_pkg::RT_FIRST) begin
      main_vld            = 1'b1;
      main_res.kind       = mbsp_pkg::KIND_RT;
      main_res.msg_length = 2'd1;
      main_res.first_byte = in_byte;
    end else if (running_status == mbsp_pkg::ST_SYSEX && !in_byte[7]) begin
      if (sysex_fill < FILL_MAX) begin
        sysex_fill_next     = sysex_fill + FW'(1);
        main_vld            = 1'b1;
        main_res.kind       = mbsp_pkg::KIND_SYSEX;
        main_res.msg_length = 2'd1;
        main_res.first_byte = in_byte;
      end
    end else begin
      close_vld = (running_status == mbsp_pkg::ST_SYSEX);
      if (in_byte[7]) begin
        running_status_next  = in_byte;
        expected_length_next = mbsp_pkg::status_length(in_byte);
        pos                  = 2'd0;
        byte_position_next   = 2'd0;
        if (in_byte == mbsp_pkg::ST_SYSEX) begin
          sysex_fill_next     = FW'(1);
          main_vld            = 1'b1;
          main_res.kind       = mbsp_pkg::KIND_SYSEX;
          main_res.msg_length = 2'd1;
          main_res.first_byte = mbsp_pkg::ST_SYSEX;
        end
      end
      if (expected_length_next != 2'd0) begin
        case (pos)
          2'd0:    mb0_next = in_byte;
          2'd1:    mb1_next = in_byte[6:0];
          2'd2:    mb2_next = in_byte[6:0];
          default: mb0_next = mb0;
        endcase
        pos1               = {1'b0, pos} + 3'd1;
        byte_position_next = pos1[1:0];
        if (pos1 >= {1'b0, expected_length_next}) begin
          main_vld             = 1'b1;
          main_res.kind        = mbsp_pkg::KIND_MSG;
          main_res.msg_length  = expected_length_next;
          main_res.first_byte  = mb0_next;
          main_res.second_byte = (expected_length_next >= 2'd2) ? mb1_next : 7'd0;
          main_res.third_byte  = (expected_length_next == 2'd3) ? mb2_next : 7'd0;
          byte_position_next   = 2'd1;
        end
      end
    end
  end

  always_comb begin
    res.vld0 = close_vld || main_vld;
    res.vld1 = close_vld && main_vld;
    res.r0   = close_vld ? close_res : main_res;
    res.r1   = main_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= '0;
      expected_length <= '0;
      byte_position   <= '0;
      sysex_fill      <= '0;
    end else if (beat_acc) begin
      running_status  <= running_status_next;
      expected_length <= expected_length_next;
      byte_position   <= byte_position_next;
      sysex_fill      <= sysex_fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_acc) begin
      mb0 <= mb0_next;
      mb1 <= mb1_next;
      mb2 <= mb2_next;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position != 2'd3)
    else $error("byte position out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    sysex_fill <= FILL_MAX)
    else $error("sysex fill past buffer limit");

  a_sysex_nolen: assert property (@(posedge clk) disable iff (rst)
    running_status == mbsp_pkg::ST_SYSEX |-> expected_length == 2'd0)
    else $error("message framing active inside sysex");
`endif

endmodule
`default_nettype wire

/* hdl/mbsp_queue.sv */
// Result queue that takes up to two results per beat and hands out one per beat.
`default_nettype none
module mbsp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 beat_acc,
  input  mbsp_pkg::result_pair_t    res,
  output logic                      full,
  output logic                      head_vld,
  input  wire logic                 head_stall,
  output mbsp_pkg::result_t         head
);

  localparam int PW = $clog2(mbsp_pkg::QUEUE_DEPTH);
  localparam int CW = PW + 1;

  mbsp_pkg::result_t q [mbsp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count, count_next;
  logic          push0;
  logic          push1;
  logic          pop;

  assign push0 = beat_acc && res.vld0;
  assign push1 = beat_acc && res.vld1;
  assign pop   = (count != '0) && !head_stall;

  assign full     = count > CW'(mbsp_pkg::QUEUE_DEPTH - 2);
  assign head_vld = count != '0;
  assign head     = q[rp];

  always_comb begin
    count_next = count + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push0) + PW'(push1);
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q[wp] <= res.r0;
    end
    if (push1) begin
      q[wp + PW'(1)] <= res.r1;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mbsp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pair_room: assert property (@(posedge clk) disable iff (rst)
    push1 |-> count <= CW'(mbsp_pkg::QUEUE_DEPTH - 2))
    else $error("two results pushed without room");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    head_vld && head_stall |=> head_vld && $stable(head))
    else $error("stalled result beat changed");
`endif

endmodule
`default_nettype wire
